[src/nec_pkg.sv]
// Shared types, timing windows and helpers for the NEC pulse decoder.
`default_nettype none

package nec_pkg;

  localparam int PW_W       = 16;
  localparam int TICK_W     = 32;
  localparam int CMD_W      = 8;
  localparam int WIN_W      = 16;
  localparam int FRAME_BITS = 32;
  localparam int CNT_W      = $clog2(FRAME_BITS);
  localparam int CMD_LSB    = 16;
  localparam int INV_LSB    = 24;

  localparam logic [WIN_W-1:0] RPT_WIN_RST = 16'd150;

  localparam logic [PW_W-1:0] HDR_MARK_LO   = 16'd8500;
  localparam logic [PW_W-1:0] HDR_MARK_HI   = 16'd9500;
  localparam logic [PW_W-1:0] HDR_SPACE_LO  = 16'd4000;
  localparam logic [PW_W-1:0] HDR_SPACE_HI  = 16'd5000;
  localparam logic [PW_W-1:0] BIT_MARK_LO   = 16'd400;
  localparam logic [PW_W-1:0] BIT_MARK_HI   = 16'd700;
  localparam logic [PW_W-1:0] ZERO_SPACE_LO = 16'd300;
  localparam logic [PW_W-1:0] ZERO_SPACE_HI = 16'd800;
  localparam logic [PW_W-1:0] ONE_SPACE_LO  = 16'd1300;
  localparam logic [PW_W-1:0] ONE_SPACE_HI  = 16'd2200;
  localparam logic [PW_W-1:0] RPT_SPACE_LO  = 16'd2000;
  localparam logic [PW_W-1:0] RPT_SPACE_HI  = 16'd2500;

  localparam logic [CMD_W-1:0] CHECK_ALL_ONES = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR_SPACE,
    ST_BIT_MARK,
    ST_BIT_SPACE
  } frame_state_t;

  typedef struct packed {
    logic [PW_W-1:0]   pulse_width_us;
    logic              is_mark;
    logic [TICK_W-1:0] now_tick;
  } pulse_t;

  typedef struct packed {
    logic [CMD_W-1:0] command_code;
    logic             is_repeat;
  } result_t;

  // Strict window: lo < w < hi
  function automatic logic in_win(input logic [PW_W-1:0] w,
                                  input logic [PW_W-1:0] lo,
                                  input logic [PW_W-1:0] hi);
    in_win = (w > lo) && (w < hi);
  endfunction

endpackage

`default_nettype wire

[src/nec_pulse_if.sv]
// Pulse channel: one measured mark or space per word.
`default_nettype none

interface nec_pulse_if import nec_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PW_W-1:0]   pulse_width_us;
  logic              is_mark;
  logic [TICK_W-1:0] now_tick;

  modport source(output valid, output pulse_width_us, output is_mark, output now_tick,
                 input ready);
  modport sink(input valid, input pulse_width_us, input is_mark, input now_tick,
               output ready);
endinterface

`default_nettype wire

[src/nec_cmd_if.sv]
// Command channel: one decoded command per word.
`default_nettype none

interface nec_cmd_if import nec_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command_code;
  logic             is_repeat;

  modport source(output valid, output command_code, output is_repeat, input ready);
  modport sink(input valid, input command_code, input is_repeat, output ready);
endinterface

`default_nettype wire

[src/nec_ir_pulse_decoder_core.sv]
// NEC infrared pulse decoder, top level.
//
// in_pulse carries one measured pulse per word: width in microseconds, mark or
// space, and the current tick. out_cmd carries one decoded command per word,
// flagged as a full frame or a repeat. Most pulses give no word at all; a
// valid 32-bit frame gives its command and a timely repeat gives the held one.
// cfg_wr_en / cfg_wr_data set the repeat window in ticks; write it only while
// no pulse is in flight.
//
// A pulse accepted into the input register is decoded into the result register
// once that register can take its outcome, and its command is then on out_cmd.
// Throughput is one pulse per cycle while out_cmd does not stall, set by the
// single compare-and-shift stage between the input and result registers.
//
// Reset (synchronous, rst_n low) empties both registers, returns the frame
// machine to idle, clears the held command and sets the window to 150 ticks.
// When out_cmd stalls with a word waiting, one more pulse is held in the input
// register and in_pulse.ready then drops until the result moves on.
`default_nettype none

module nec_ir_pulse_decoder_core import nec_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  nec_pulse_if.sink             in_pulse,
  nec_cmd_if.source             out_cmd,
  input  wire logic             cfg_wr_en,
  input  wire logic [WIN_W-1:0] cfg_wr_data
);

  logic [WIN_W-1:0] rpt_win_r;
  pulse_t           pls;
  logic             pls_vld;
  logic             slot_free;
  logic             fire;
  logic             res_vld;
  result_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpt_win_r <= RPT_WIN_RST;
    end else if (cfg_wr_en) begin
      rpt_win_r <= cfg_wr_data;
    end
  end

  // Decode the held pulse when the result register can take its outcome
  assign fire = pls_vld && slot_free;

  nec_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pulse (in_pulse),
    .take     (fire),
    .pls      (pls),
    .pls_vld  (pls_vld)
  );

  nec_frame_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .pls     (pls),
    .rpt_win (rpt_win_r),
    .res_vld (res_vld),
    .res     (res)
  );

  nec_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_vld   (res_vld),
    .res       (res),
    .slot_free (slot_free),
    .out_cmd   (out_cmd)
  );

`ifndef SYNTHESIS
  a_in_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !pls_vld |-> in_pulse.ready)
    else $error("input register empty but ready low");

  a_mark_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && pls.is_mark |-> !res_vld)
    else $error("mark pulse produced a result");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_vld |=> out_cmd.valid && out_cmd.command_code == $past(res.command_code))
    else $error("decoded result not presented");
`endif

endmodule

`default_nettype wire

[src/nec_in_stage.sv]
// Input register for the pulse channel.
`default_nettype none

module nec_in_stage import nec_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  nec_pulse_if.sink    in_pulse,
  input  wire logic    take,
  output pulse_t       pls,
  output logic         pls_vld
);

  logic   vld_r;
  pulse_t pls_r;

  // Accept when empty or when the held word leaves this cycle
  assign in_pulse.ready = !vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_pulse.ready) begin
      vld_r <= in_pulse.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pulse.valid && in_pulse.ready) begin
      pls_r.pulse_width_us <= in_pulse.pulse_width_us;
      pls_r.is_mark        <= in_pulse.is_mark;
      pls_r.now_tick       <= in_pulse.now_tick;
    end
  end

  assign pls     = pls_r;
  assign pls_vld = vld_r;

endmodule

`default_nettype wire

[src/nec_frame_fsm.sv]
// Frame state machine: header checks, bit shifting, frame check and repeat handling.
`default_nettype none

module nec_frame_fsm import nec_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire pulse_t           pls,
  input  wire logic [WIN_W-1:0] rpt_win,
  output logic                  res_vld,
  output result_t               res
);

  frame_state_t      state_r, state_nxt;
  logic [FRAME_BITS-1:0] data_r, data_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CMD_W-1:0]  held_r, held_nxt;
  logic              held_vld_r, held_vld_nxt;
  logic [TICK_W-1:0] last_tick_r, last_tick_nxt;

  logic [TICK_W-1:0] age;
  logic              age_ok;
  logic              is_one;
  logic              is_zero;
  logic [FRAME_BITS-1:0] shifted;
  logic [CMD_W-1:0]  cmd;
  logic [CMD_W-1:0]  inv;

  assign age     = pls.now_tick - last_tick_r;
  assign age_ok  = age < {{(TICK_W-WIN_W){1'b0}}, rpt_win};
  assign is_one  = in_win(pls.pulse_width_us, ONE_SPACE_LO, ONE_SPACE_HI);
  assign is_zero = in_win(pls.pulse_width_us, ZERO_SPACE_LO, ZERO_SPACE_HI);
  // LSB first: each new bit enters at the top and moves down
  assign shifted = {is_one, data_r[FRAME_BITS-1:1]};
  assign cmd     = shifted[CMD_LSB +: CMD_W];
  assign inv     = shifted[INV_LSB +: CMD_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      data_r      <= '0;
      cnt_r       <= '0;
      held_r      <= '0;
      held_vld_r  <= 1'b0;
      last_tick_r <= '0;
    end else begin
      state_r     <= state_nxt;
      data_r      <= data_nxt;
      cnt_r       <= cnt_nxt;
      held_r      <= held_nxt;
      held_vld_r  <= held_vld_nxt;
      last_tick_r <= last_tick_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    data_nxt      = data_r;
    cnt_nxt       = cnt_r;
    held_nxt      = held_r;
    held_vld_nxt  = held_vld_r;
    last_tick_nxt = last_tick_r;
    res_vld       = 1'b0;
    res           = '0;
    if (fire) begin
      if (pls.is_mark) begin
        case (state_r)
          ST_IDLE: begin
            if (in_win(pls.pulse_width_us, HDR_MARK_LO, HDR_MARK_HI)) begin
              state_nxt = ST_HDR_SPACE;
            end
          end
          ST_BIT_MARK: begin
            state_nxt = in_win(pls.pulse_width_us, BIT_MARK_LO, BIT_MARK_HI) ?
                        ST_BIT_SPACE : ST_IDLE;
          end
          default: ;
        endcase
      end else begin
        case (state_r)
          ST_HDR_SPACE: begin
            if (in_win(pls.pulse_width_us, HDR_SPACE_LO, HDR_SPACE_HI)) begin
              data_nxt  = '0;
              cnt_nxt   = '0;
              state_nxt = ST_BIT_MARK;
            end else begin
              state_nxt = ST_IDLE;
              if (in_win(pls.pulse_width_us, RPT_SPACE_LO, RPT_SPACE_HI) &&
                  held_vld_r && age_ok) begin
                res_vld          = 1'b1;
                res.command_code = held_r;
                res.is_repeat    = 1'b1;
              end
            end
          end
          ST_BIT_SPACE: begin
            if (is_one || is_zero) begin
              data_nxt = shifted;
              if (cnt_r == CNT_W'(FRAME_BITS - 1)) begin
                state_nxt = ST_IDLE;
                cnt_nxt   = '0;
                if ((cmd ^ inv) == CHECK_ALL_ONES) begin
                  held_nxt         = cmd;
                  held_vld_nxt     = 1'b1;
                  last_tick_nxt    = pls.now_tick;
                  res_vld          = 1'b1;
                  res.command_code = cmd;
                  res.is_repeat    = 1'b0;
                end else begin
                  // drop the held command on a failed check
                  held_nxt     = '0;
                  held_vld_nxt = 1'b0;
                end
              end else begin
                cnt_nxt   = cnt_r + 1'b1;
                state_nxt = ST_BIT_MARK;
              end
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[src/nec_out_stage.sv]
// Result register for the command channel.
`default_nettype none

module nec_out_stage import nec_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire logic    res_vld,
  input  wire result_t res,
  output logic         slot_free,
  nec_cmd_if.source    out_cmd
);

  logic    vld_r;
  result_t res_r;

  assign slot_free = !vld_r || out_cmd.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= res_vld;
    end else if (out_cmd.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_vld) begin
      res_r <= res;
    end
  end

  assign out_cmd.valid        = vld_r;
  assign out_cmd.command_code = res_r.command_code;
  assign out_cmd.is_repeat    = res_r.is_repeat;

endmodule

`default_nettype wire

[test/tb_nec_ir_pulse_decoder_core.sv]
// Testbench for the NEC pulse decoder core: directed and random pulse trains checked against a decoder model.
module tb_nec_ir_pulse_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import nec_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 500000;
  localparam int SETTLE       = 6;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [WIN_W-1:0] cfg_wr_data;

  nec_pulse_if pulse_if ();
  nec_cmd_if   cmd_if ();

  nec_ir_pulse_decoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pulse   (pulse_if),
    .out_cmd    (cmd_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  // stimulus and expectation stores
  pulse_t  pulse_q[$];
  result_t cmd_expect_q[$];

  // decoder model state
  frame_state_t     dec_state  = ST_IDLE;
  logic [31:0]      dec_shift  = '0;
  logic [5:0]       dec_count  = '0;
  logic [CMD_W-1:0] held_cmd   = '0;
  logic             held_ok    = 1'b0;
  logic [31:0]      held_tick  = '0;
  logic [WIN_W-1:0] rpt_window = RPT_WIN_RST;

  int          err_count      = 0;
  int          pushed_total   = 0;
  int unsigned cycle_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_req       = 0;
  int          hold_ack       = 0;
  int          hold_left      = 0;
  bit          pulse_took     = 1'b0;
  bit          tick_free      = 1'b0;
  bit          width_edges    = 1'b0;
  logic [31:0] tick_cursor    = '0;

  function automatic bit strictly_between(input logic [PW_W-1:0] w,
                                          input logic [PW_W-1:0] lo,
                                          input logic [PW_W-1:0] hi);
    return (w > lo) && (w < hi);
  endfunction

  // Advance the model by one accepted word, queue any command it yields.
  task automatic decode_pulse(input pulse_t p);
    logic [31:0]      bit_mask;
    logic [31:0]      age;
    logic [CMD_W-1:0] cmd_b;
    logic [CMD_W-1:0] inv_b;
    bit               bit_ok;
    result_t          r;
    if (p.is_mark) begin
      if (dec_state == ST_IDLE) begin
        if (strictly_between(p.pulse_width_us, HDR_MARK_LO, HDR_MARK_HI))
          dec_state = ST_HDR_SPACE;
      end else if (dec_state == ST_BIT_MARK) begin
        dec_state = strictly_between(p.pulse_width_us, BIT_MARK_LO, BIT_MARK_HI) ?
                    ST_BIT_SPACE : ST_IDLE;
      end
    end else if (dec_state == ST_HDR_SPACE) begin
      if (strictly_between(p.pulse_width_us, HDR_SPACE_LO, HDR_SPACE_HI)) begin
        dec_shift = '0;
        dec_count = '0;
        dec_state = ST_BIT_MARK;
      end else begin
        dec_state = ST_IDLE;
        age = p.now_tick - held_tick;
        if (strictly_between(p.pulse_width_us, RPT_SPACE_LO, RPT_SPACE_HI) && held_ok &&
            age < {16'd0, rpt_window}) begin
          r.command_code = held_cmd;
          r.is_repeat    = 1'b1;
          cmd_expect_q.push_back(r);
        end
      end
    end else if (dec_state == ST_BIT_SPACE) begin
      bit_mask = 32'd1 << dec_count[4:0];
      bit_ok   = 1'b1;
      if (strictly_between(p.pulse_width_us, ONE_SPACE_LO, ONE_SPACE_HI))
        dec_shift = dec_shift | bit_mask;
      else if (strictly_between(p.pulse_width_us, ZERO_SPACE_LO, ZERO_SPACE_HI))
        dec_shift = dec_shift & ~bit_mask;
      else
        bit_ok = 1'b0;
      if (!bit_ok) begin
        dec_state = ST_IDLE;
      end else begin
        dec_count = dec_count + 6'd1;
        if (dec_count >= FRAME_BITS) begin
          cmd_b     = dec_shift[CMD_LSB +: CMD_W];
          inv_b     = dec_shift[INV_LSB +: CMD_W];
          dec_state = ST_IDLE;
          if ((cmd_b ^ inv_b) == CHECK_ALL_ONES) begin
            held_cmd       = cmd_b;
            held_ok        = 1'b1;
            held_tick      = p.now_tick;
            r.command_code = cmd_b;
            r.is_repeat    = 1'b0;
            cmd_expect_q.push_back(r);
          end else begin
            held_cmd = '0;
            held_ok  = 1'b0;
          end
        end else begin
          dec_state = ST_BIT_MARK;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin : watch_ports
    result_t want;
    if (!rst_n) begin
      pulse_took = 1'b0;
    end else begin
      pulse_took = pulse_if.valid && pulse_if.ready;
      if (pulse_took)
        decode_pulse({pulse_if.pulse_width_us, pulse_if.is_mark, pulse_if.now_tick});
      if (cmd_if.valid && cmd_if.ready) begin
        if (cmd_expect_q.size() == 0) begin
          report_mismatch("command word with none pending", cmd_if.command_code, 0);
        end else begin
          want = cmd_expect_q.pop_front();
          if (cmd_if.command_code !== want.command_code)
            report_mismatch("command_code", cmd_if.command_code, want.command_code);
          if (cmd_if.is_repeat !== want.is_repeat)
            report_mismatch("is_repeat", cmd_if.is_repeat, want.is_repeat);
        end
      end
    end
  end

  // offer the next pending word once the current one is taken
  always @(negedge clk) begin : drive_pulses
    pulse_t nxt;
    if (rst_n && (!pulse_if.valid || pulse_took)) begin
      if (pulse_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pulse_q.pop_front();
        pulse_if.valid          <= 1'b1;
        pulse_if.pulse_width_us <= nxt.pulse_width_us;
        pulse_if.is_mark        <= nxt.is_mark;
        pulse_if.now_tick       <= nxt.now_tick;
      end else begin
        pulse_if.valid <= 1'b0;
      end
    end
  end

  // result side: random stalls plus an occasional long hold-off
  always @(negedge clk) begin : drive_ready
    if (hold_left > 0) begin
      cmd_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      cmd_if.ready <= 1'b0;
    end else begin
      cmd_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : run_limit
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("nec_ir_pulse_decoder_core: mismatch");
      $finish;
    end
  end

  function automatic logic [PW_W-1:0] good_width(input int unsigned lo, input int unsigned hi);
    if (width_edges || $urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? PW_W'(lo + 1) : PW_W'(hi - 1);
    return PW_W'($urandom_range(lo + 1, hi - 1));
  endfunction

  function automatic logic [PW_W-1:0] bad_width(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 4))
      0:       return PW_W'(lo);
      1:       return PW_W'(hi);
      2:       return PW_W'($urandom_range(0, lo));
      3:       return PW_W'($urandom_range(hi, 65535));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic [31:0] make_frame(input bit check_ok);
    logic [7:0] c;
    logic [7:0] inv;
    c   = 8'($urandom);
    inv = check_ok ? ~c : ~c ^ (8'd1 << $urandom_range(0, 7));
    return {inv, c, 16'($urandom)};
  endfunction

  task automatic push_pulse(input logic [PW_W-1:0] w, input bit mark);
    pulse_t p;
    int     r;
    p.pulse_width_us = w;
    p.is_mark        = mark;
    p.now_tick       = tick_cursor;
    pulse_q.push_back(p);
    pushed_total++;
    if (tick_free) begin
      r = $urandom_range(0, 99);
      if (r < 2)
        tick_cursor = $urandom;
      else if (r < 10)
        tick_cursor = tick_cursor + $urandom_range(0, 300);
      else
        tick_cursor = tick_cursor + $urandom_range(0, 3);
    end
  endtask

  // Header, then 32 bits LSB first; cut_at breaks the word at that index and stops.
  task automatic send_frame(input logic [31:0] data, input int cut_at, input int junk_pct);
    int              idx;
    bit              mark_pulse;
    bit              cut;
    logic [PW_W-1:0] w;
    for (idx = 0; idx < 2 + 2 * FRAME_BITS; idx++) begin
      mark_pulse = (idx % 2 == 0);
      cut        = (idx == cut_at);
      // wrong-kind pulse, to be ignored
      if ($urandom_range(0, 99) < junk_pct)
        push_pulse(PW_W'($urandom_range(0, 65535)), !mark_pulse);
      if (idx == 0)
        w = cut ? bad_width(HDR_MARK_LO, HDR_MARK_HI) : good_width(HDR_MARK_LO, HDR_MARK_HI);
      else if (idx == 1)
        w = cut ? bad_width(HDR_SPACE_LO, HDR_SPACE_HI) : good_width(HDR_SPACE_LO, HDR_SPACE_HI);
      else if (mark_pulse)
        w = cut ? bad_width(BIT_MARK_LO, BIT_MARK_HI) : good_width(BIT_MARK_LO, BIT_MARK_HI);
      else if (cut)
        w = $urandom_range(0, 1) ? bad_width(ONE_SPACE_LO, ONE_SPACE_HI) :
                                   bad_width(ZERO_SPACE_LO, ZERO_SPACE_HI);
      else if (data[(idx - 3) / 2])
        w = good_width(ONE_SPACE_LO, ONE_SPACE_HI);
      else
        w = good_width(ZERO_SPACE_LO, ZERO_SPACE_HI);
      push_pulse(w, mark_pulse);
      if (cut)
        return;
    end
  endtask

  task automatic send_repeat(input bit good_space);
    push_pulse(good_width(HDR_MARK_LO, HDR_MARK_HI), 1'b1);
    push_pulse(good_space ? good_width(RPT_SPACE_LO, RPT_SPACE_HI) :
                            bad_width(RPT_SPACE_LO, RPT_SPACE_HI), 1'b0);
  endtask

  // Mostly clean frames and repeats, with broken frames and noise mixed in.
  task automatic random_traffic(input int n_pulses);
    int start;
    int r;
    start = pushed_total;
    while (pushed_total - start < n_pulses) begin
      r = $urandom_range(0, 99);
      if (r < 22)
        send_frame(make_frame(1'b1), -1, ($urandom_range(0, 3) == 0) ? 10 : 0);
      else if (r < 77)
        repeat ($urandom_range(1, 6)) send_repeat($urandom_range(0, 9) != 0);
      else if (r < 87)
        send_frame(make_frame(1'b1), $urandom_range(0, 65), 0);
      else if (r < 93)
        send_frame(make_frame(1'b0), -1, 0);
      else
        repeat ($urandom_range(1, 4))
          push_pulse(PW_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Hold until every pending word is taken and every command has come, then settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (pulse_q.size() != 0 || pulse_if.valid || cmd_expect_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    rpt_window  = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  initial begin
    rst_n                   = 1'b0;
    cfg_wr_en               = 1'b0;
    cfg_wr_data             = '0;
    pulse_if.valid          = 1'b0;
    pulse_if.pulse_width_us = '0;
    pulse_if.is_mark        = 1'b0;
    pulse_if.now_tick       = '0;
    cmd_if.ready            = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: window at its reset value, ticks set by hand
    tick_free   = 1'b0;
    tick_cursor = 32'd1000;
    push_pulse(16'd3000, 1'b0);                      // space in idle
    push_pulse(HDR_MARK_LO, 1'b1);
    push_pulse(HDR_MARK_HI, 1'b1);
    push_pulse(16'h0000, 1'b1);
    push_pulse(16'hFFFF, 1'b1);
    push_pulse(16'd4500, 1'b0);
    push_pulse(HDR_MARK_LO + 16'd1, 1'b1);
    push_pulse(16'd600, 1'b1);                       // mark in header space
    push_pulse(RPT_SPACE_LO + 16'd1, 1'b0);          // repeat, nothing held
    push_pulse(HDR_MARK_HI - 16'd1, 1'b1);
    push_pulse(HDR_SPACE_HI, 1'b0);                  // neither header nor repeat
    width_edges = 1'b1;
    send_frame({8'hFF, 8'h00, 16'hA55A}, -1, 100);   // junk before every pulse
    width_edges = 1'b0;
    tick_cursor = 32'd1149;
    send_repeat(1'b1);                               // one tick inside the window
    tick_cursor = 32'd1150;
    send_repeat(1'b1);                               // window just expired
    tick_cursor = 32'd1010;
    push_pulse(HDR_MARK_LO + 16'd1, 1'b1);
    push_pulse(RPT_SPACE_HI, 1'b0);
    push_pulse(HDR_MARK_LO + 16'd1, 1'b1);
    push_pulse(RPT_SPACE_LO, 1'b0);
    tick_cursor = 32'hFFFF_FFF0;
    send_frame({8'h00, 8'hFF, 16'hFFFF}, -1, 0);
    tick_cursor = 32'h0000_0010;
    send_repeat(1'b1);                               // age taken across the wrap
    send_frame(make_frame(1'b0), -1, 0);             // check failure drops the held command
    send_repeat(1'b1);
    send_frame(make_frame(1'b1), 1, 0);
    send_frame(make_frame(1'b1), 2, 0);
    send_frame(make_frame(1'b1), 33, 0);
    send_frame(make_frame(1'b1), 65, 0);
    tick_cursor = 32'd5000;
    send_frame(make_frame(1'b1), -1, 0);             // leave a command held
    wait_idle();

    // widest window, no idling; stall the result side while repeats pile up
    write_window(16'hFFFF);
    set_idling(0, 0);
    repeat (12) send_repeat(1'b1);
    hold_req++;
    tick_free = 1'b1;
    random_traffic(150);
    wait_idle();

    // zero window: repeats never accepted
    write_window(16'h0000);
    set_idling(47, 0);
    random_traffic(150);
    wait_idle();

    write_window(WIN_W'($urandom_range(1, 60)));
    set_idling(0, 47);
    random_traffic(150);
    wait_idle();

    write_window(WIN_W'($urandom_range(100, 2000)));
    set_idling(34, 34);
    random_traffic(75);
    wait_idle();
    random_traffic(75);
    wait_idle();

    write_window(WIN_W'(1));
    set_idling(0, 0);
    random_traffic(90);
    wait_idle();

    if (err_count == 0)
      $display("nec_ir_pulse_decoder_core: match");
    else
      $display("nec_ir_pulse_decoder_core: mismatch");
    $finish;
  end

endmodule
